[design/plg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Precision landing guidance package
// Widths, register indexes, reset values, guidance constants and the structs
// that pass between the guidance modules.
// ----------------------------------------------------------------------------
package plg_pkg;

  // Payload widths
  localparam int unsigned POS_W   = 24;
  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned CMD_W   = 24;
  localparam int unsigned VZ_W    = 17;
  localparam int unsigned ALT_W   = 23;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned PHASE_W = 2;

  // APB port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_APPROACH_ALT = 2'd0;
  localparam logic [1:0] REG_FINAL_ALT    = 2'd1;
  localparam logic [1:0] REG_LAND_SPEED   = 2'd2;
  localparam logic [1:0] REG_HORIZ_GAIN   = 2'd3;

  // Register reset values
  localparam logic [ALT_W-1:0]  APPROACH_ALT_RST = 23'd20000;
  localparam logic [ALT_W-1:0]  FINAL_ALT_RST    = 23'd5000;
  localparam logic [SPD_W-1:0]  LAND_SPEED_RST   = 16'd500;
  localparam logic [GAIN_W-1:0] HORIZ_GAIN_RST   = 16'd77;

  // Phase codes as they leave the block
  localparam logic [PHASE_W-1:0] PHASE_APPROACH  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_DESCENT   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_FINAL     = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_TOUCHDOWN = 2'd3;

  // Altitude thresholds in mm
  localparam int DESCENT_MARGIN = 1000;
  localparam int TOUCHDOWN_ALT  = 500;
  localparam int GROUND_ALT     = 100;
  localparam int ABORT_ALT      = 10000;

  // Vertical rate commands in mm/s
  localparam logic signed [VZ_W-1:0] VZ_APPROACH = -17'sd500;
  localparam logic signed [VZ_W-1:0] VZ_DESCENT  = -17'sd1000;
  localparam logic signed [VZ_W-1:0] VZ_SETTLE   = -17'sd200;
  localparam logic signed [VZ_W-1:0] VZ_STOP     = 17'sd0;

  // Horizontal command limits
  localparam logic signed [CMD_W-1:0] CMD_MAX = 24'sh7FFFFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 24'sh800000;

  typedef struct packed {
    logic [ALT_W-1:0]  approach_alt;
    logic [ALT_W-1:0]  final_alt;
    logic [SPD_W-1:0]  land_speed;
    logic [GAIN_W-1:0] horiz_gain;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]      phase_next;
    logic signed [VZ_W-1:0]  vz;
    logic                    dbl_gain;
    logic                    zero_h;
  } phase_dec_t;

endpackage

[design/plg_sens_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor channel
// Vehicle and target positions, altitude and target-detected flag.
// ----------------------------------------------------------------------------
interface plg_sens_if import plg_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] vehicle_x;
  logic signed [POS_W-1:0] vehicle_y;
  logic signed [POS_W-1:0] vehicle_z;
  logic signed [POS_W-1:0] vehicle_altitude;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;
  logic                    target_detected;

  modport source (
    output valid, vehicle_x, vehicle_y, vehicle_z, vehicle_altitude,
           target_x, target_y, target_z, target_detected,
    input  ready
  );

  modport sink (
    input  valid, vehicle_x, vehicle_y, vehicle_z, vehicle_altitude,
           target_x, target_y, target_z, target_detected,
    output ready
  );

endinterface

[design/plg_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Velocity commands, abort flag and landing phase after the update.
// ----------------------------------------------------------------------------
interface plg_cmd_if import plg_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] command_vx;
  logic signed [CMD_W-1:0] command_vy;
  logic signed [VZ_W-1:0]  command_vz;
  logic                    abort_landing;
  logic [PHASE_W-1:0]      phase_after;

  modport source (
    output valid, command_vx, command_vy, command_vz, abort_landing, phase_after,
    input  ready
  );

  modport sink (
    input  valid, command_vx, command_vy, command_vz, abort_landing, phase_after,
    output ready
  );

endinterface

[design/plg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Guidance configuration registers
// APB register file: approach and final altitudes, landing speed and gain.
// ----------------------------------------------------------------------------
module plg_cfg import plg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.approach_alt <= APPROACH_ALT_RST;
      cfg_q.final_alt    <= FINAL_ALT_RST;
      cfg_q.land_speed   <= LAND_SPEED_RST;
      cfg_q.horiz_gain   <= HORIZ_GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_APPROACH_ALT: cfg_q.approach_alt <= pwdata[ALT_W-1:0];
        REG_FINAL_ALT:    cfg_q.final_alt    <= pwdata[ALT_W-1:0];
        REG_LAND_SPEED:   cfg_q.land_speed   <= pwdata[SPD_W-1:0];
        REG_HORIZ_GAIN:   cfg_q.horiz_gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_APPROACH_ALT: prdata = {{(APB_DW-ALT_W){1'b0}}, cfg_q.approach_alt};
      REG_FINAL_ALT:    prdata = {{(APB_DW-ALT_W){1'b0}}, cfg_q.final_alt};
      REG_LAND_SPEED:   prdata = {{(APB_DW-SPD_W){1'b0}}, cfg_q.land_speed};
      REG_HORIZ_GAIN:   prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_q.horiz_gain};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/plg_phase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landing phase sequencer
// Holds the landing phase, decodes the per-phase command choices and
// advances the phase on altitude thresholds.
// ----------------------------------------------------------------------------
module plg_phase import plg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic signed [POS_W-1:0] alt_i,
  input  cfg_t                    cfg_i,
  output phase_dec_t              dec_o,
  output logic [PHASE_W-1:0]      phase_o
);

  typedef enum logic [PHASE_W-1:0] {
    PH_APPROACH  = 2'd0,
    PH_DESCENT   = 2'd1,
    PH_FINAL     = 2'd2,
    PH_TOUCHDOWN = 2'd3
  } phase_e;

  localparam int unsigned CMP_W = POS_W + 2;

  phase_e                  phase_q;
  phase_e                  phase_d;
  logic signed [CMP_W-1:0] alt_ext;
  logic signed [CMP_W-1:0] descent_lim;
  logic signed [CMP_W-1:0] final_lim;

  assign alt_ext     = CMP_W'(alt_i);
  assign descent_lim = $signed({{(CMP_W-ALT_W){1'b0}}, cfg_i.approach_alt})
                       + CMP_W'(DESCENT_MARGIN);
  assign final_lim   = $signed({{(CMP_W-ALT_W){1'b0}}, cfg_i.final_alt});

  always_comb begin
    phase_d        = phase_q;
    dec_o.vz       = VZ_STOP;
    dec_o.dbl_gain = 1'b0;
    dec_o.zero_h   = 1'b0;
    unique case (phase_q)
      PH_APPROACH: begin
        dec_o.vz = VZ_APPROACH;
        if (alt_ext <= descent_lim) phase_d = PH_DESCENT;
      end
      PH_DESCENT: begin
        dec_o.vz = VZ_DESCENT;
        if (alt_ext <= final_lim) phase_d = PH_FINAL;
      end
      PH_FINAL: begin
        dec_o.vz       = -$signed({1'b0, cfg_i.land_speed});
        dec_o.dbl_gain = 1'b1;
        if (alt_ext <= CMP_W'(TOUCHDOWN_ALT)) phase_d = PH_TOUCHDOWN;
      end
      PH_TOUCHDOWN: begin
        dec_o.zero_h = 1'b1;
        dec_o.vz     = (alt_ext <= CMP_W'(GROUND_ALT)) ? VZ_STOP : VZ_SETTLE;
      end
      default: ;
    endcase
    dec_o.phase_next = phase_d;
  end

  // Advance only when the staged item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_APPROACH;
    end else if (adv_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

[design/plg_hcmd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horizontal command unit
// Gain (x2 on request) times error, floor shift by 8, 24-bit saturate or zero.
// ----------------------------------------------------------------------------
module plg_hcmd import plg_pkg::*; (
  input  logic signed [ERR_W-1:0] err_i,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic                    dbl_i,
  input  logic                    zero_i,
  output logic signed [CMD_W-1:0] cmd_o
);

  localparam int unsigned GEFF_W = GAIN_W + 1;
  localparam int unsigned PROD_W = ERR_W + GEFF_W + 1;
  localparam int unsigned SHR    = 8;
  localparam int unsigned Q_W    = PROD_W - SHR;

  logic [GEFF_W-1:0]       gain_eff;
  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    q;
  logic                     in_range;

  assign gain_eff = dbl_i ? {gain_i, 1'b0} : {1'b0, gain_i};
  assign prod     = err_i * $signed({1'b0, gain_eff});
  // Floor division by 256: drop the low bits of the two's complement product.
  assign q        = prod[PROD_W-1:SHR];
  assign in_range = (~|q[Q_W-1:CMD_W-1]) | (&q[Q_W-1:CMD_W-1]);

  always_comb begin
    if (zero_i) begin
      cmd_o = '0;
    end else if (in_range) begin
      cmd_o = q[CMD_W-1:0];
    end else begin
      cmd_o = q[Q_W-1] ? CMD_MIN : CMD_MAX;
    end
  end

endmodule

[design/precision_landing_phase_guidance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Precision landing phase guidance
// Turns vehicle/target position updates into velocity commands while
// stepping through the approach, descent, final and touchdown phases.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Carries
//   sens_i    in         valid/ready     positions, altitude, target seen flag
//   cmd_o     out        valid/ready     vx, vy, vz, abort, phase after update
//   APB       in/out     psel/penable    approach/final altitude, speed, gain
//
// Each transaction passes through the input stage (position error) and then
// the result register: one transaction per cycle while the result register
// is not stalled. The rate is set by the two-bit phase register, which
// updates as a staged transaction moves into the result register, so the
// next one sees it. Reset leaves the phase in approach and the registers at
// their defaults. A stalled result holds in the result register; while it
// is full and unconsumed, the input stage takes a transaction only if empty.
// ----------------------------------------------------------------------------
module precision_landing_phase_guidance import plg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  plg_sens_if.sink          sens_i,
  plg_cmd_if.source         cmd_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // Input stage
  logic                    s1_vld_q;
  logic signed [ERR_W-1:0] s1_err_x_q;
  logic signed [ERR_W-1:0] s1_err_y_q;
  logic signed [POS_W-1:0] s1_alt_q;
  logic                    s1_det_q;
  logic signed [ERR_W-1:0] err_x_d;
  logic signed [ERR_W-1:0] err_y_d;

  // Result register
  logic                    out_vld_q;
  logic signed [CMD_W-1:0] vx_q;
  logic signed [CMD_W-1:0] vy_q;
  logic signed [VZ_W-1:0]  vz_q;
  logic                    abort_q;
  logic [PHASE_W-1:0]      phase_out_q;
  logic signed [CMD_W-1:0] vx_d;
  logic signed [CMD_W-1:0] vy_d;
  logic                    abort_d;

  logic                    out_adv;
  logic                    s1_adv;
  logic                    in_take;
  phase_dec_t              dec;
  logic [PHASE_W-1:0]      phase_now;

  plg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the result register frees when empty or consumed; the input
  // stage takes a new transaction when empty or when its content moves on.
  assign out_adv      = !out_vld_q || cmd_o.ready;
  assign s1_adv       = s1_vld_q && out_adv;
  assign sens_i.ready = !s1_vld_q || out_adv;
  assign in_take      = sens_i.valid && sens_i.ready;

  // Position error, target minus vehicle, one bit wider than the inputs.
  assign err_x_d = ERR_W'(sens_i.target_x) - ERR_W'(sens_i.vehicle_x);
  assign err_y_d = ERR_W'(sens_i.target_y) - ERR_W'(sens_i.vehicle_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (sens_i.ready) begin
      s1_vld_q <= sens_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_err_x_q <= err_x_d;
      s1_err_y_q <= err_y_d;
      s1_alt_q   <= sens_i.vehicle_altitude;
      s1_det_q   <= sens_i.target_detected;
    end
  end

  // Phase held before the update picks the command; advance on load.
  plg_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .alt_i   (s1_alt_q),
    .cfg_i   (cfg),
    .dec_o   (dec),
    .phase_o (phase_now)
  );

  plg_hcmd u_hcmd_x (
    .err_i  (s1_err_x_q),
    .gain_i (cfg.horiz_gain),
    .dbl_i  (dec.dbl_gain),
    .zero_i (dec.zero_h),
    .cmd_o  (vx_d)
  );

  plg_hcmd u_hcmd_y (
    .err_i  (s1_err_y_q),
    .gain_i (cfg.horiz_gain),
    .dbl_i  (dec.dbl_gain),
    .zero_i (dec.zero_h),
    .cmd_o  (vy_d)
  );

  // Abort: target lost below the abort altitude; commands are unaffected.
  assign abort_d = !s1_det_q && (s1_alt_q < POS_W'(ABORT_ALT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      vz_q        <= dec.vz;
      abort_q     <= abort_d;
      phase_out_q <= dec.phase_next;
    end
  end

  assign cmd_o.valid         = out_vld_q;
  assign cmd_o.command_vx    = vx_q;
  assign cmd_o.command_vy    = vy_q;
  assign cmd_o.command_vz    = vz_q;
  assign cmd_o.abort_landing = abort_q;
  assign cmd_o.phase_after   = phase_out_q;

`ifndef ASSERT_OFF
  // A staged transaction that moves on must land in the result register.
  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("staged transaction lost on its way to the result register");

  // Hold the phase unless a transaction moves into the result register.
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(phase_now))
    else $error("landing phase changed without a transaction");

  // The phase steps forward by at most one and never leaves touchdown.
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (phase_now == $past(phase_now)) ||
               (($past(phase_now) != PHASE_TOUCHDOWN) &&
                (phase_now == $past(phase_now) + 2'd1)))
    else $error("landing phase skipped a step or left touchdown");

  // A pending result reports the phase that the sequencer now holds.
  a_phase_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (phase_out_q == phase_now))
    else $error("reported phase differs from the held phase");
`endif

endmodule

[tb/sv/plg_guidance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landing guidance checker
// Watches the sensor, command and register ports of the guidance block. It
// keeps its own copy of the phase and the registers, predicts the command for
// every sensor transaction and compares each command transaction with it.
// ----------------------------------------------------------------------------
module plg_guidance_checker import plg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  plg_sens_if               sens_i,
  plg_cmd_if                cmd_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fails_o,
  output int                results_o,
  output int                pending_o
);

  localparam longint SAT_HI    = longint'(CMD_MAX);
  localparam longint SAT_LO    = longint'(CMD_MIN);
  localparam int     PRINT_CAP = 100;

  typedef struct packed {
    logic signed [POS_W-1:0] veh_x;
    logic signed [POS_W-1:0] veh_y;
    logic signed [POS_W-1:0] alt;
    logic signed [POS_W-1:0] tgt_x;
    logic signed [POS_W-1:0] tgt_y;
    logic                    detected;
  } sensor_sample_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] vx;
    logic signed [CMD_W-1:0] vy;
    logic signed [VZ_W-1:0]  vz;
    logic                    abort_flag;
    logic [PHASE_W-1:0]      phase;
  } guidance_cmd_t;

  logic [ALT_W-1:0]   approach_alt_q;
  logic [ALT_W-1:0]   final_alt_q;
  logic [SPD_W-1:0]   speed_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [PHASE_W-1:0] phase_q;

  guidance_cmd_t  expected_cmds[$];
  guidance_cmd_t  want;
  sensor_sample_t sample;
  int             mismatch_cnt = 0;
  int             commands_seen;
  int             pending_q;

  assign fails_o   = mismatch_cnt;
  assign results_o = commands_seen;
  assign pending_o = pending_q;

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) begin
      $display("%0t ns: command %0d: %s", $time, commands_seen, what);
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("%s is %0d, should be %0d", name, got, exp_v));
    end
  endtask

  // Gain times error, floor shift by 8, clamp to the command range.
  function automatic logic signed [CMD_W-1:0] steer(input longint gain, input longint err);
    longint cmd_v;
    cmd_v = (gain * err) >>> 8;
    if (cmd_v > SAT_HI) cmd_v = SAT_HI;
    if (cmd_v < SAT_LO) cmd_v = SAT_LO;
    return cmd_v[CMD_W-1:0];
  endfunction

  function automatic guidance_cmd_t predict_guidance(input sensor_sample_t s,
                                                     input logic [PHASE_W-1:0] held);
    guidance_cmd_t c;
    longint        alt;
    longint        err_x;
    longint        err_y;
    longint        gain;
    alt   = longint'($signed(s.alt));
    err_x = longint'($signed(s.tgt_x)) - longint'($signed(s.veh_x));
    err_y = longint'($signed(s.tgt_y)) - longint'($signed(s.veh_y));
    gain  = longint'(gain_q);
    c       = '0;
    c.phase = held;
    case (held)
      PHASE_APPROACH: begin
        c.vx = steer(gain, err_x);
        c.vy = steer(gain, err_y);
        c.vz = VZ_APPROACH;
        if (alt <= longint'(approach_alt_q) + DESCENT_MARGIN) c.phase = PHASE_DESCENT;
      end
      PHASE_DESCENT: begin
        c.vx = steer(gain, err_x);
        c.vy = steer(gain, err_y);
        c.vz = VZ_DESCENT;
        if (alt <= longint'(final_alt_q)) c.phase = PHASE_FINAL;
      end
      PHASE_FINAL: begin
        c.vx = steer(2 * gain, err_x);
        c.vy = steer(2 * gain, err_y);
        c.vz = -$signed({1'b0, speed_q});
        if (alt <= TOUCHDOWN_ALT) c.phase = PHASE_TOUCHDOWN;
      end
      default: begin
        c.vz = (alt <= GROUND_ALT) ? VZ_STOP : VZ_SETTLE;
      end
    endcase
    c.abort_flag = !s.detected && (alt < ABORT_ALT);
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      approach_alt_q = APPROACH_ALT_RST;
      final_alt_q    = FINAL_ALT_RST;
      speed_q        = LAND_SPEED_RST;
      gain_q         = HORIZ_GAIN_RST;
      phase_q        = PHASE_APPROACH;
      expected_cmds.delete();
      commands_seen <= 0;
      pending_q     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_APPROACH_ALT: approach_alt_q = pwdata[ALT_W-1:0];
          REG_FINAL_ALT:    final_alt_q    = pwdata[ALT_W-1:0];
          REG_LAND_SPEED:   speed_q        = pwdata[SPD_W-1:0];
          REG_HORIZ_GAIN:   gain_q         = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      // Retire the oldest expectation before queuing a new one.
      if (cmd_i.valid && cmd_i.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("transaction with no command expected");
        end else begin
          want = expected_cmds.pop_front();
          check_field("command_vx", 64'(cmd_i.command_vx), 64'(want.vx));
          check_field("command_vy", 64'(cmd_i.command_vy), 64'(want.vy));
          check_field("command_vz", 64'(cmd_i.command_vz), 64'(want.vz));
          check_field("abort_landing", {63'd0, cmd_i.abort_landing}, {63'd0, want.abort_flag});
          check_field("phase_after", {62'd0, cmd_i.phase_after}, {62'd0, want.phase});
        end
        commands_seen <= commands_seen + 1;
      end
      if (sens_i.valid && sens_i.ready) begin
        sample.veh_x    = sens_i.vehicle_x;
        sample.veh_y    = sens_i.vehicle_y;
        sample.alt      = sens_i.vehicle_altitude;
        sample.tgt_x    = sens_i.target_x;
        sample.tgt_y    = sens_i.target_y;
        sample.detected = sens_i.target_detected;
        want    = predict_guidance(sample, phase_q);
        phase_q = want.phase;
        expected_cmds.push_back(want);
      end
      pending_q <= expected_cmds.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landing guidance testbench
// Walks the guidance block once through approach, descent, final and
// touchdown. Each phase opens with hand-picked transactions at the edges of
// the fields and registers, then random position and altitude updates that
// keep the phase in place, then, but for touchdown, the exact altitude that
// moves it on. A checker beside the block predicts and compares every command.
// ----------------------------------------------------------------------------
module tb import plg_pkg::*; ();

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int HOLD_CYCLES    = 60;
  localparam int SEG_ITEMS      = 30;
  localparam int TIMEOUT_CYCLES = 100000;
  localparam int ALT_TOP        = 8388607;
  localparam int ALT_REG_TOP    = 8388607;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  plg_sens_if sens_if ();
  plg_cmd_if  cmd_if ();

  int fails;
  int results_seen;
  int pending_cmds;

  // Bookkeeping owned by the stimulus process
  int items_sent    = 0;
  int reg_writes    = 0;
  int burst_left    = 0;
  int cur_phase     = 0;
  int phase_items[4];

  // Hold-off requests: raised by the stimulus, served by the receiver
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;

  precision_landing_phase_guidance i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sens_i  (sens_if),
    .cmd_o   (cmd_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  plg_guidance_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sens_i    (sens_if),
    .cmd_i     (cmd_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fails_o   (fails),
    .results_o (results_seen),
    .pending_o (pending_cmds)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Command receiver. Ready follows stretches of random style: always ready,
  // coin flip, mostly stalled, or mostly ready. A hold-off request takes
  // precedence and keeps ready low until it is served, so the block backs up
  // and stalls the sensor channel while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int run_left;
    int style;
    run_left = 0;
    style    = 0;
    cmd_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_done_cnt != hold_req_cnt) begin
        cmd_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done_cnt++;
      end else begin
        if (run_left == 0) begin
          style    = $urandom_range(0, 3);
          run_left = $urandom_range(4, 50);
        end
        run_left--;
        case (style)
          0:       cmd_if.ready <= 1'b1;
          1:       cmd_if.ready <= 1'($urandom_range(0, 1));
          2:       cmd_if.ready <= ($urandom_range(0, 4) == 0);
          default: cmd_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sensor side
  // --------------------------------------------------------------------------

  // Offer one sensor transaction and hold it until the block takes it. The
  // sender runs in bursts; between bursts it may drop valid.
  task automatic offer(input logic [POS_W-1:0] veh_x, veh_y, veh_z, alt,
                       input logic [POS_W-1:0] tgt_x, tgt_y, tgt_z,
                       input logic seen);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        sens_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    sens_if.vehicle_x        <= veh_x;
    sens_if.vehicle_y        <= veh_y;
    sens_if.vehicle_z        <= veh_z;
    sens_if.vehicle_altitude <= alt;
    sens_if.target_x         <= tgt_x;
    sens_if.target_y         <= tgt_y;
    sens_if.target_z         <= tgt_z;
    sens_if.target_detected  <= seen;
    sens_if.valid            <= 1'b1;
    do @(posedge clk_i); while (sens_if.ready !== 1'b1);
    items_sent++;
    phase_items[cur_phase]++;
  endtask

  // Random positions at a given altitude. Half the time the vehicle sits
  // within a few metres of the target so the commands stay out of the clamp.
  task automatic offer_at(input int alt);
    logic [POS_W-1:0] vx;
    logic [POS_W-1:0] vy;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
    vx = POS_W'($urandom());
    vy = POS_W'($urandom());
    if ($urandom_range(0, 1)) begin
      tx = vx + POS_W'($urandom_range(0, 10000)) - 24'd5000;
      ty = vy + POS_W'($urandom_range(0, 10000)) - 24'd5000;
    end else begin
      tx = POS_W'($urandom());
      ty = POS_W'($urandom());
    end
    offer(vx, vy, POS_W'($urandom()), POS_W'(alt), tx, ty, POS_W'($urandom()),
          1'($urandom_range(0, 1)));
  endtask

  // Altitude at or above lo: often close to lo (abort band, thresholds),
  // otherwise anywhere up to the top of the range.
  function automatic int alt_from(input int lo);
    int hi;
    hi = ($urandom_range(0, 9) < 4 && lo <= ALT_TOP - 12000) ? lo + 12000 : ALT_TOP;
    return $urandom_range(lo, hi);
  endfunction

  // Any altitude, negative ones too; touchdown has no way out.
  function automatic int alt_any();
    logic [POS_W-1:0] r;
    if ($urandom_range(0, 1)) return int'($urandom_range(0, 12400)) - 200;
    r = POS_W'($urandom());
    return $signed(r);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return HORIZ_GAIN_RST;
      3:       return 16'd1;
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // Stop offering and wait until every command has come back, then let the
  // two-stage pipe settle.
  task automatic drain();
    sens_if.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Register side
  // --------------------------------------------------------------------------

  // Setup then access phase. psel stays high across back-to-back writes so
  // no signal is assigned twice at one edge; the caller drops it afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    reg_writes++;
  endtask

  // Write all four registers, with junk above each field to exercise masking.
  task automatic load_guidance_regs(input logic [ALT_W-1:0] appr, fin,
                                    input logic [SPD_W-1:0] spd,
                                    input logic [GAIN_W-1:0] gain);
    logic [APB_DW-1:0] junk;
    junk = $urandom();
    write_reg(REG_APPROACH_ALT, {junk[APB_DW-1:ALT_W], appr});
    junk = $urandom();
    write_reg(REG_FINAL_ALT, {junk[APB_DW-1:ALT_W], fin});
    junk = $urandom();
    write_reg(REG_LAND_SPEED, {junk[APB_DW-1:SPD_W], spd});
    junk = $urandom();
    write_reg(REG_HORIZ_GAIN, {junk[APB_DW-1:GAIN_W], gain});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. The phase only moves forward and reset comes once, so the run
  // is ordered by phase: each block of random updates uses altitudes that
  // keep the current phase, and one exact-threshold update moves it on.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int appr;
    int fin;
    for (int p = 0; p < 4; p++) phase_items[p] = 0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sens_if.valid            = 1'b0;
    sens_if.vehicle_x        = '0;
    sens_if.vehicle_y        = '0;
    sens_if.vehicle_z        = '0;
    sens_if.vehicle_altitude = '0;
    sens_if.target_x         = '0;
    sens_if.target_y         = '0;
    sens_if.target_z         = '0;
    sens_if.target_detected  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Approach -----------------------------------------------------------
    cur_phase = 0;
    // Register defaults: largest errors both ways, extreme z, top altitude.
    offer(24'h800000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF,
          24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
    // One millimetre off: floor takes -77/256 down to -1, +77/256 to 0.
    // Altitude one above the default descent threshold holds approach.
    offer(24'd1, 24'hFFFFFF, 24'h7FFFFF, 24'd21001, 24'd0, 24'd0, 24'h800000, 1'b1);
    drain();
    // Top gain clamps both commands; zero error; abort band edges.
    load_guidance_regs('0, '0, LAND_SPEED_RST, '1);
    offer(24'h800000, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd0, 1'b1);
    offer(24'd1234, 24'd1234, 24'd0, 24'd1001, 24'd1234, 24'd1234, 24'd0, 1'b0);
    offer_at(ABORT_ALT - 1);
    offer(24'd5, 24'd5, 24'd0, POS_W'(ABORT_ALT), 24'd6, 24'd4, 24'd0, 1'b0);
    drain();
    // Zero gain zeroes the command whatever the error.
    load_guidance_regs(ALT_W'(ALT_REG_TOP - 1001), '0, '0, '0);
    offer(24'h800000, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd0, 1'b1);

    for (int seg = 0; seg < 4; seg++) begin
      drain();
      case (seg)
        0:       appr = 0;
        1:       appr = $urandom_range(0, 30000);
        2:       appr = APPROACH_ALT_RST;
        default: appr = $urandom_range(0, 8000000);
      endcase
      load_guidance_regs(ALT_W'(appr), ALT_W'($urandom()), SPD_W'($urandom()),
                         pick_gain());
      if (seg == 1) hold_req_cnt++;
      repeat (SEG_ITEMS) offer_at(alt_from(appr + DESCENT_MARGIN + 1));
    end

    // Exact threshold: one above holds, equal moves to descent.
    drain();
    appr = $urandom_range(1000, 50000);
    load_guidance_regs(ALT_W'(appr), '0, SPD_W'($urandom()), HORIZ_GAIN_RST);
    offer_at(appr + DESCENT_MARGIN + 1);
    offer_at(appr + DESCENT_MARGIN);

    // ---- Descent ------------------------------------------------------------
    cur_phase = 1;
    offer_at(1);
    drain();
    load_guidance_regs('1, '0, '1, '1);
    offer(24'h7FFFFF, 24'h800000, 24'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd0, 1'b1);

    for (int seg = 0; seg < 4; seg++) begin
      drain();
      case (seg)
        0:       fin = 0;
        1:       fin = $urandom_range(0, 30000);
        2:       fin = FINAL_ALT_RST;
        default: fin = $urandom_range(0, 8000000);
      endcase
      load_guidance_regs(ALT_W'($urandom()), ALT_W'(fin), SPD_W'($urandom()),
                         pick_gain());
      if (seg == 2) hold_req_cnt++;
      repeat (SEG_ITEMS) offer_at(alt_from(fin + 1));
    end

    // One above the final altitude holds; then the top setting with the top
    // altitude, equal, moves to final.
    drain();
    fin = $urandom_range(1000, 50000);
    load_guidance_regs(ALT_W'($urandom()), ALT_W'(fin), SPD_W'($urandom()),
                       pick_gain());
    offer_at(fin + 1);
    drain();
    load_guidance_regs(ALT_W'($urandom()), '1, '0, '1);
    offer_at(ALT_TOP);

    // ---- Final --------------------------------------------------------------
    cur_phase = 2;
    // Doubled top gain, zero landing speed.
    offer(24'h800000, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd0, 1'b0);
    drain();
    // Unit gain doubled: -2/256 floors to -1. Top landing speed. Holds at 501.
    load_guidance_regs(ALT_W'($urandom()), ALT_W'($urandom()), '1, 16'd1);
    offer(24'd1, 24'd0, 24'd0, POS_W'(TOUCHDOWN_ALT + 1), 24'd0, 24'd1, 24'd0, 1'b0);

    for (int seg = 0; seg < 4; seg++) begin
      drain();
      load_guidance_regs(ALT_W'($urandom()), ALT_W'($urandom()),
                         (seg == 0) ? 16'd0 : SPD_W'($urandom()), pick_gain());
      if (seg == 1) hold_req_cnt++;
      repeat (SEG_ITEMS) offer_at(alt_from(TOUCHDOWN_ALT + 1));
    end
    offer_at(TOUCHDOWN_ALT);

    // ---- Touchdown ----------------------------------------------------------
    cur_phase = 3;
    offer_at(GROUND_ALT);
    offer_at(GROUND_ALT + 1);
    offer(24'h123456, 24'h654321, 24'd0, 24'h800000, 24'h000001, 24'hFFFFFF, 24'd0, 1'b0);
    repeat (SEG_ITEMS / 2) offer_at(alt_any());
    drain();
    load_guidance_regs(ALT_W'($urandom()), ALT_W'($urandom()), SPD_W'($urandom()),
                       pick_gain());
    repeat (SEG_ITEMS / 2) offer_at(alt_any());

    // ---- Wrap up ------------------------------------------------------------
    drain();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d sensor transactions (approach %0d, descent %0d, final %0d,",
             items_sent, phase_items[0], phase_items[1], phase_items[2]);
    $display("summary: touchdown %0d), %0d register writes, %0d hold-offs, %0d checked",
             phase_items[3], reg_writes, hold_done_cnt, results_seen);
    if (fails == 0 && pending_cmds == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
